// ===== sv/mcwd_pkg.sv =====
// shared types and codes for the multi channel watchdog table
// used by mcwd_ctrl, mcwd_datapath and the top level; no dependencies
package mcwd_pkg;

  localparam int unsigned DefChannels = 16;
  localparam int unsigned KeyW        = 16;
  localparam int unsigned CountW      = 16;
  localparam int unsigned CmdW        = 2;
  localparam int unsigned StatusW     = 3;

  localparam logic [CmdW-1:0] CMD_TICK  = 2'd0;
  localparam logic [CmdW-1:0] CMD_REG   = 2'd1;
  localparam logic [CmdW-1:0] CMD_DEREG = 2'd2;
  localparam logic [CmdW-1:0] CMD_FEED  = 2'd3;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_SMALL    = 3'd1;
  localparam logic [StatusW-1:0] ST_DUP      = 3'd2;
  localparam logic [StatusW-1:0] ST_NOKEY    = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd4;
  localparam logic [StatusW-1:0] ST_RESTART  = 3'd5;
  localparam logic [StatusW-1:0] ST_TICKDONE = 3'd6;

  // largest limit that is refused at register
  localparam logic [CountW-1:0] LimitMin = 16'd2;

  typedef struct packed {
    logic load;
    logic advance;
    logic out_restart;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic last_slot;
    logic restart_hit;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/mcwd_ctrl.sv =====
// sequencer for the watchdog table: accepts a word, steps the slot scan
// and issues the final result; uses mcwd_pkg
module mcwd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  mcwd_pkg::stat_t stat_i,
  output mcwd_pkg::ctrl_t ctrl_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // hold the slot while a restart word cannot be placed
        if (!stat_i.restart_hit || stat_i.out_free) begin
          ctrl_o.advance     = 1'b1;
          ctrl_o.out_restart = stat_i.restart_hit;
          if (stat_i.last_slot) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/mcwd_datapath.sv =====
// slot memories, scan pointer, search flags and output register of the
// watchdog table; driven by mcwd_ctrl, uses mcwd_pkg
module mcwd_datapath #(
  parameter int unsigned Channels = mcwd_pkg::DefChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcwd_pkg::ctrl_t                ctrl_i,
  output mcwd_pkg::stat_t                stat_o,
  input  logic [mcwd_pkg::CmdW-1:0]      cmd_i,
  input  logic [mcwd_pkg::KeyW-1:0]      key_i,
  input  logic [mcwd_pkg::CountW-1:0]    limit_i,
  input  logic [mcwd_pkg::CountW-1:0]    grace_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [mcwd_pkg::StatusW-1:0]   out_status_o,
  output logic [mcwd_pkg::KeyW-1:0]      out_key_o,
  output logic                           out_last_o
);

  localparam int unsigned IdxW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Channels - 1);
  localparam int unsigned CfgW = mcwd_pkg::KeyW + 2 * mcwd_pkg::CountW;
  localparam int unsigned RunW = mcwd_pkg::CountW + 1;

  logic [CfgW-1:0] cfg_mem [Channels];
  logic [RunW-1:0] run_mem [Channels];
  logic [CfgW-1:0] cfg_rd_q;
  logic [RunW-1:0] run_rd_q;

  logic [mcwd_pkg::CmdW-1:0]   cmd_q;
  logic [mcwd_pkg::KeyW-1:0]   key_q;
  logic [mcwd_pkg::CountW-1:0] limit_q;
  logic [mcwd_pkg::CountW-1:0] grace_q;

  logic [IdxW-1:0]     eidx_q;
  logic [Channels-1:0] valid_q;
  logic                match_q;
  logic [IdxW-1:0]     match_idx_q;
  logic                match_start_q;
  logic                free_q;
  logic [IdxW-1:0]     free_idx_q;

  logic                         out_valid_q;
  logic [mcwd_pkg::StatusW-1:0] out_status_q;
  logic [mcwd_pkg::KeyW-1:0]    out_key_q;
  logic                         out_last_q;

  logic [mcwd_pkg::KeyW-1:0]   rd_key;
  logic [mcwd_pkg::CountW-1:0] rd_limit;
  logic [mcwd_pkg::CountW-1:0] rd_grace;
  logic [mcwd_pkg::CountW-1:0] rd_count;
  logic                        rd_start;
  logic                        slot_valid;
  logic [mcwd_pkg::CountW-1:0] cnt_inc;
  logic                        grace_hit;
  logic                        limit_hit;
  logic                        key_hit;
  logic                        is_tick;
  logic [IdxW-1:0]             next_idx;
  logic [IdxW-1:0]             rd_addr;
  logic                        out_free;

  logic                         reg_ok;
  logic [mcwd_pkg::StatusW-1:0] fin_status;
  logic [mcwd_pkg::KeyW-1:0]    fin_key;

  logic            run_we;
  logic [IdxW-1:0] run_waddr;
  logic [RunW-1:0] run_wdata;

  assign rd_key   = cfg_rd_q[mcwd_pkg::KeyW-1:0];
  assign rd_limit = cfg_rd_q[mcwd_pkg::KeyW +: mcwd_pkg::CountW];
  assign rd_grace = cfg_rd_q[mcwd_pkg::KeyW + mcwd_pkg::CountW +: mcwd_pkg::CountW];
  assign rd_count = run_rd_q[mcwd_pkg::CountW-1:0];
  assign rd_start = run_rd_q[mcwd_pkg::CountW];

  assign slot_valid = valid_q[eidx_q];
  assign is_tick    = (cmd_q == mcwd_pkg::CMD_TICK);
  assign cnt_inc    = rd_count + 16'd1;
  assign grace_hit  = rd_start && (cnt_inc >= rd_grace);
  assign limit_hit  = !rd_start && (cnt_inc >= rd_limit);
  assign key_hit    = slot_valid && (rd_key == key_q);
  assign next_idx   = (eidx_q == LastIdx) ? '0 : eidx_q + 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (ctrl_i.load) begin
      rd_addr = '0;
    end else if (ctrl_i.advance) begin
      rd_addr = next_idx;
    end else begin
      rd_addr = eidx_q;
    end
  end

  assign stat_o.last_slot   = (eidx_q == LastIdx);
  assign stat_o.restart_hit = is_tick && slot_valid && limit_hit;
  assign stat_o.out_free    = out_free;

  assign reg_ok = (cmd_q == mcwd_pkg::CMD_REG) && (limit_q > mcwd_pkg::LimitMin)
                  && !match_q && free_q;

  always_comb begin
    fin_key = key_q;
    case (cmd_q)
      mcwd_pkg::CMD_TICK: begin
        fin_status = mcwd_pkg::ST_TICKDONE;
        fin_key    = '0;
      end
      mcwd_pkg::CMD_REG: begin
        if (limit_q <= mcwd_pkg::LimitMin) begin
          fin_status = mcwd_pkg::ST_SMALL;
        end else if (match_q) begin
          fin_status = mcwd_pkg::ST_DUP;
        end else if (!free_q) begin
          fin_status = mcwd_pkg::ST_FULL;
        end else begin
          fin_status = mcwd_pkg::ST_OK;
        end
      end
      default: begin
        fin_status = match_q ? mcwd_pkg::ST_OK : mcwd_pkg::ST_NOKEY;
      end
    endcase
  end

  // counter and start flag write back
  always_comb begin
    run_we    = 1'b0;
    run_waddr = eidx_q;
    run_wdata = '0;
    if (ctrl_i.advance && is_tick && slot_valid) begin
      run_we    = 1'b1;
      run_wdata = {rd_start && !grace_hit,
                   (grace_hit || limit_hit) ? '0 : cnt_inc};
    end else if (ctrl_i.finish && reg_ok) begin
      run_we    = 1'b1;
      run_waddr = free_idx_q;
      run_wdata = {1'b1, {mcwd_pkg::CountW{1'b0}}};
    end else if (ctrl_i.finish && (cmd_q == mcwd_pkg::CMD_FEED) && match_q) begin
      run_we    = 1'b1;
      run_waddr = match_idx_q;
      run_wdata = {match_start_q, {mcwd_pkg::CountW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    run_rd_q <= run_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish && reg_ok) begin
      cfg_mem[free_idx_q] <= {grace_q, limit_q, key_q};
    end
    cfg_rd_q <= cfg_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_i;
      key_q   <= key_i;
      limit_q <= limit_i;
      grace_q <= grace_i;
    end
    if (ctrl_i.advance && !match_q && key_hit) begin
      match_idx_q   <= eidx_q;
      match_start_q <= rd_start;
    end
    if (ctrl_i.advance && !free_q && !slot_valid) begin
      free_idx_q <= eidx_q;
    end
    if (ctrl_i.out_restart) begin
      out_status_q <= mcwd_pkg::ST_RESTART;
      out_key_q    <= rd_key;
      out_last_q   <= 1'b0;
    end else if (ctrl_i.finish) begin
      out_status_q <= fin_status;
      out_key_q    <= fin_key;
      out_last_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eidx_q      <= '0;
      valid_q     <= '0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      eidx_q <= rd_addr;
      if (ctrl_i.load) begin
        match_q <= 1'b0;
        free_q  <= 1'b0;
      end else if (ctrl_i.advance) begin
        if (key_hit) begin
          match_q <= 1'b1;
        end
        if (!slot_valid) begin
          free_q <= 1'b1;
        end
      end
      if (ctrl_i.finish && reg_ok) begin
        valid_q[free_idx_q] <= 1'b1;
      end else if (ctrl_i.finish && (cmd_q == mcwd_pkg::CMD_DEREG) && match_q) begin
        valid_q[match_idx_q] <= 1'b0;
      end
      if (ctrl_i.out_restart || ctrl_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_key_o    = out_key_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== sv/multi_channel_watchdog_table_top.sv =====
// Watchdog table of Channels slots keyed by a 16-bit client id. Every input
// word (tick, register, deregister or feed) is handled by one pass over all
// slots, reading one slot a cycle from the slot memories while no result
// word is held back, followed by a closing step that issues the result;
// each result word that finds the output register still occupied holds
// the pass until it drains. A tick gives one restart word per expiring
// channel in slot order and then a tick-done word with tlast set; every
// other command gives a single word with tlast set.
// top level: joins mcwd_ctrl and mcwd_datapath, uses mcwd_pkg
module multi_channel_watchdog_table_top #(
  parameter int unsigned Channels = mcwd_pkg::DefChannels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // client_key, restart_limit, start_grace
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // event_key
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast
);

  mcwd_pkg::ctrl_t ctrl;
  mcwd_pkg::stat_t stat;

  mcwd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  mcwd_datapath #(
    .Channels (Channels)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .cmd_i        (s_axis_tuser),
    .key_i        (s_axis_tdata[15:0]),
    .limit_i      (s_axis_tdata[31:16]),
    .grace_i      (s_axis_tdata[47:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_key_o    (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for multi_channel_watchdog_table_top: directed table, then random
// command mix checked word by word against an in-bench model of the channel table
// depends on mcwd_pkg and multi_channel_watchdog_table_top
module testbench;

  localparam int Slots      = mcwd_pkg::DefChannels;
  localparam int PlanRows   = 24;
  localparam int QuietLimit = 3000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [mcwd_pkg::StatusW-1:0] status;
    logic [mcwd_pkg::KeyW-1:0]    key;
    logic                         last;
  } wd_word_t;

  typedef struct packed {
    logic [mcwd_pkg::CmdW-1:0]    cmd;
    logic [mcwd_pkg::KeyW-1:0]    key;
    logic [mcwd_pkg::CountW-1:0]  lim;
    logic [mcwd_pkg::CountW-1:0]  grace;
    logic                         typed;
    logic [mcwd_pkg::StatusW-1:0] status;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // client_key, restart_limit, start_grace
  logic [1:0]  s_axis_tuser = '0;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // event_key
  logic [2:0]  m_axis_tuser;        // status
  logic        m_axis_tlast;

  // channel table as the bench sees it
  logic                        chan_live     [Slots];
  logic [mcwd_pkg::KeyW-1:0]   chan_key      [Slots];
  logic [mcwd_pkg::CountW-1:0] chan_count    [Slots];
  logic                        chan_starting [Slots];
  logic [mcwd_pkg::CountW-1:0] chan_limit    [Slots];
  logic [mcwd_pkg::CountW-1:0] chan_grace    [Slots];

  wd_word_t                  pending_events [$];
  plan_row_t                 plan [PlanRows];
  logic [mcwd_pkg::KeyW-1:0] key_pool [20];

  int   faults = 0;
  int   quiet_cycles = 0;
  logic idle_on = 1'b1;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  multi_channel_watchdog_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // expected words for one accepted command, table updated as the block should
  task automatic apply_command(input logic [mcwd_pkg::CmdW-1:0] cmd,
                               input logic [mcwd_pkg::KeyW-1:0] key,
                               input logic [mcwd_pkg::CountW-1:0] lim,
                               input logic [mcwd_pkg::CountW-1:0] grace);
    int hit;
    int spot;
    logic [mcwd_pkg::CountW-1:0] c;
    hit  = -1;
    spot = -1;
    for (int i = 0; i < Slots; i++) begin
      if (chan_live[i] && chan_key[i] == key && hit < 0) hit = i;
      if (!chan_live[i] && spot < 0) spot = i;
    end
    case (cmd)
      mcwd_pkg::CMD_TICK: begin
        for (int i = 0; i < Slots; i++) begin
          if (chan_live[i]) begin
            c = chan_count[i] + 16'd1;
            if (chan_starting[i]) begin
              if (c >= chan_grace[i]) begin
                chan_starting[i] = 1'b0;
                c = '0;
              end
            end else if (c >= chan_limit[i]) begin
              pending_events.push_back('{status: mcwd_pkg::ST_RESTART,
                                         key: chan_key[i], last: 1'b0});
              c = '0;
            end
            chan_count[i] = c;
          end
        end
        pending_events.push_back('{status: mcwd_pkg::ST_TICKDONE, key: '0, last: 1'b1});
      end
      mcwd_pkg::CMD_REG: begin
        if (lim <= mcwd_pkg::LimitMin) begin
          pending_events.push_back('{status: mcwd_pkg::ST_SMALL, key: key, last: 1'b1});
        end else if (hit >= 0) begin
          pending_events.push_back('{status: mcwd_pkg::ST_DUP, key: key, last: 1'b1});
        end else if (spot < 0) begin
          pending_events.push_back('{status: mcwd_pkg::ST_FULL, key: key, last: 1'b1});
        end else begin
          chan_live[spot]     = 1'b1;
          chan_key[spot]      = key;
          chan_count[spot]    = '0;
          chan_starting[spot] = 1'b1;
          chan_limit[spot]    = lim;
          chan_grace[spot]    = grace;
          pending_events.push_back('{status: mcwd_pkg::ST_OK, key: key, last: 1'b1});
        end
      end
      default: begin
        if (hit < 0) begin
          pending_events.push_back('{status: mcwd_pkg::ST_NOKEY, key: key, last: 1'b1});
        end else begin
          if (cmd == mcwd_pkg::CMD_DEREG) chan_live[hit] = 1'b0;
          else chan_count[hit] = '0;
          pending_events.push_back('{status: mcwd_pkg::ST_OK, key: key, last: 1'b1});
        end
      end
    endcase
  endtask

  // called just after a rising edge
  task automatic send_word(input logic [mcwd_pkg::CmdW-1:0] cmd,
                           input logic [mcwd_pkg::KeyW-1:0] key,
                           input logic [mcwd_pkg::CountW-1:0] lim,
                           input logic [mcwd_pkg::CountW-1:0] grace);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {grace, lim, key};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_command(cmd, key, lim, grace);
  endtask

  task automatic maybe_pause();
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_command(input int reg_pct);
    logic [mcwd_pkg::KeyW-1:0] live_keys [$];
    logic [mcwd_pkg::CmdW-1:0] cmd;
    logic [mcwd_pkg::KeyW-1:0] key;
    logic [mcwd_pkg::CountW-1:0] lim;
    logic [mcwd_pkg::CountW-1:0] grace;
    int roll;
    for (int i = 0; i < Slots; i++)
      if (chan_live[i]) live_keys.push_back(chan_key[i]);
    roll = $urandom_range(0, 99);
    if (roll < reg_pct) cmd = mcwd_pkg::CMD_REG;
    else if (roll < reg_pct + 15) cmd = mcwd_pkg::CMD_DEREG;
    else if (roll < reg_pct + 40) cmd = mcwd_pkg::CMD_FEED;
    else cmd = mcwd_pkg::CMD_TICK;
    if ($urandom_range(0, 9) == 0) key = 16'($urandom);
    else key = key_pool[$urandom_range(0, 19)];
    if (cmd != mcwd_pkg::CMD_REG && live_keys.size() != 0 && $urandom_range(0, 3) != 0)
      key = live_keys[$urandom_range(0, live_keys.size() - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      lim   = 16'($urandom_range(3, 12));
      grace = 16'($urandom_range(0, 6));
    end else if (roll == 7) begin
      lim   = 16'($urandom_range(0, 2));
      grace = 16'($urandom);
    end else begin
      lim   = 16'($urandom);
      grace = 16'($urandom);
    end
    send_word(cmd, key, lim, grace);
    maybe_pause();
  endtask

  // receiving side: random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen     <= hold_ask;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output checker
  always @(posedge clk_i) begin
    wd_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: status %0d key %h last %0d",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata !== want.key ||
            m_axis_tlast !== want.last) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: expected status %0d key %h last %0d, %s %0d key %h last %0d",
                     want.status, want.key, want.last, "got status",
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    plan = '{
      '{mcwd_pkg::CMD_TICK,  16'hBEEF, 16'h1234, 16'h5678, 1'b1, mcwd_pkg::ST_TICKDONE},
      '{mcwd_pkg::CMD_FEED,  16'h1234, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_NOKEY},
      '{mcwd_pkg::CMD_DEREG, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_NOKEY},
      '{mcwd_pkg::CMD_REG,   16'h0000, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_SMALL},
      '{mcwd_pkg::CMD_REG,   16'hFFFF, 16'h0002, 16'hFFFF, 1'b1, mcwd_pkg::ST_SMALL},
      '{mcwd_pkg::CMD_REG,   16'hFFFF, 16'h0003, 16'h0000, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_REG,   16'hFFFF, 16'h0009, 16'h0001, 1'b1, mcwd_pkg::ST_DUP},
      '{mcwd_pkg::CMD_REG,   16'hFFFF, 16'h0001, 16'h0000, 1'b1, mcwd_pkg::ST_SMALL},
      '{mcwd_pkg::CMD_REG,   16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_REG,   16'h00A5, 16'h0003, 16'h0002, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_FEED,  16'h00A5, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_DEREG, 16'h0000, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_REG,   16'h5A5A, 16'h0004, 16'h0000, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_DEREG, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_OK},
      '{mcwd_pkg::CMD_FEED,  16'hFFFF, 16'h0000, 16'h0000, 1'b1, mcwd_pkg::ST_NOKEY},
      '{mcwd_pkg::CMD_TICK,  16'h0000, 16'h0000, 16'h0000, 1'b0, mcwd_pkg::ST_OK}
    };
    for (int i = 0; i < Slots; i++) begin
      chan_live[i]     = 1'b0;
      chan_key[i]      = '0;
      chan_count[i]    = '0;
      chan_starting[i] = 1'b0;
      chan_limit[i]    = '0;
      chan_grace[i]    = '0;
    end
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < 20; i++) key_pool[i] = 16'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table; typed rows carry their single word by hand
    for (int r = 0; r < PlanRows; r++) begin
      send_word(plan[r].cmd, plan[r].key, plan[r].lim, plan[r].grace);
      if (plan[r].typed) begin
        void'(pending_events.pop_back());
        pending_events.push_back('{status: plan[r].status,
                                   key: (plan[r].cmd == mcwd_pkg::CMD_TICK) ? '0 : plan[r].key,
                                   last: 1'b1});
      end
      maybe_pause();
    end
    drain();

    // fill the table while the receiver holds off
    hold_ask <= hold_ask + 1;
    for (int n = 0; n < 40; n++) random_command(70);
    for (int n = 0; n < 120; n++) begin
      idle_on <= (n % 64) < 48;
      random_command(25);
    end
    drain();

    for (int n = 0; n < 180; n++) begin
      idle_on <= (n % 64) < 48;
      random_command(20);
    end

    // closing stretch with no idling
    idle_on <= 1'b0;
    for (int n = 0; n < 110; n++) random_command(25);
    drain();
    repeat (3 * Slots) @(posedge clk_i);

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
